// ----- hdl/spsr_pkg.sv -----
package spsr_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] pulse;
    logic [7:0]  angle;
    logic [15:0] move_ms;
    logic [23:0] speed_q8;
    logic [15:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [12:0] compare_us;
    logic [15:0] current;
    logic [15:0] target;
    logic        moving;
    logic [23:0] speed_now;
  } out_word_t;

  localparam logic [2:0] CMD_SET_PULSE    = 3'd0;
  localparam logic [2:0] CMD_SET_ANGLE    = 3'd1;
  localparam logic [2:0] CMD_SMOOTH_PULSE = 3'd2;
  localparam logic [2:0] CMD_SMOOTH_ANGLE = 3'd3;
  localparam logic [2:0] CMD_SET_SPEED    = 3'd4;
  localparam logic [2:0] CMD_STOP         = 3'd5;
  localparam logic [2:0] CMD_TICK         = 3'd6;

  localparam logic CFG_MIN_PULSE = 1'b0;
  localparam logic CFG_MAX_PULSE = 1'b1;

  localparam logic [15:0] MIN_PULSE_RST = 16'd5000;
  localparam logic [15:0] MAX_PULSE_RST = 16'd25000;
  localparam logic [15:0] PULSE_RST     = 16'd15000;
  localparam logic [15:0] ANGLE_BASE    = 16'd5000;
  localparam logic [7:0]  ANGLE_MAX     = 8'd180;
  localparam logic [23:0] SPEED_SAT     = 24'hFFFFFF;
  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_RECIP   = 16'd52429;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_init;
    logic div_step;
    logic apply;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic smooth_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // 5000 + floor(a * 1000 / 9) = 5000 + 111 * a + floor(a / 9), a saturated at 180;
  // floor(a / 9) == (a * 57) >> 9 over that range
  function automatic logic [15:0] angle_to_pulse(input logic [7:0] a);
    logic [7:0]  a_sat;
    logic [14:0] p111;
    logic [13:0] p57;
    a_sat = (a > ANGLE_MAX) ? ANGLE_MAX : a;
    p111  = 15'(a_sat) * 15'd111;
    p57   = 14'(a_sat) * 14'd57;
    return ANGLE_BASE + 16'(p111) + 16'(p57[13:9]);
  endfunction

endpackage

// ----- hdl/spsr_ctrl.sv -----
module spsr_ctrl
  import spsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_DIST  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        ctl.prep  = 1'b1;
        state_nxt = stat.smooth_div ? ST_DIST : ST_APPLY;
      end
      ST_DIST: begin
        ctl.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_APPLY;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      ST_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/spsr_dpath.sv -----
module spsr_dpath
  import spsr_pkg::*;
#(
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [15:0] cfg_wdata,
  input  in_word_t  in_data,
  input  ctl_cmd_t  ctl,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int DVD_W = 16 + SPEED_FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [23:0] SPEED_RST = 24'(32'd10 << SPEED_FRAC_BITS);

  logic [15:0] min_r, max_r;
  in_word_t    item_r;
  logic [15:0] p_r;
  logic [39:0] prod_r;
  logic [15:0] cur_r, tgt_r;
  logic [23:0] spd_r;
  logic        act_r;
  logic [DVD_W-1:0] dvd_r;
  logic [15:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic        out_valid_r;
  out_word_t   out_data_r;

  logic [15:0] cur_nxt, tgt_nxt;
  logic [23:0] spd_nxt;
  logic        act_nxt;

  logic [15:0] raw_pulse, clamped;
  logic [15:0] dist_p, dist_t;
  logic [16:0] shifted, diff;
  logic [31:0] q_ext;
  logic [23:0] need;
  logic [39:0] move;
  logic [31:0] prod10;
  logic        is_smooth;

  assign is_smooth = (item_r.cmd == CMD_SMOOTH_PULSE) || (item_r.cmd == CMD_SMOOTH_ANGLE);
  assign raw_pulse = ((item_r.cmd == CMD_SET_PULSE) || (item_r.cmd == CMD_SMOOTH_PULSE)) ?
                     item_r.pulse : angle_to_pulse(item_r.angle);
  // when the limits cross, a pulse below the low limit gets the low limit and any other the high one
  assign clamped = (raw_pulse < min_r) ? min_r :
                   (raw_pulse > max_r) ? max_r : raw_pulse;

  assign dist_p  = (p_r >= cur_r) ? (p_r - cur_r) : (cur_r - p_r);
  assign dist_t  = (tgt_r > cur_r) ? (tgt_r - cur_r) : (cur_r - tgt_r);
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, item_r.move_ms};
  assign q_ext   = 32'(dvd_r);
  assign need    = (|q_ext[31:24]) ? SPEED_SAT : q_ext[23:0];
  assign move    = prod_r >> SPEED_FRAC_BITS;
  assign prod10  = 32'(cur_r) * 32'(DIV10_RECIP);

  assign stat.smooth_div = is_smooth && (item_r.move_ms != 16'd0);
  assign stat.div_done   = (cnt_r == CNT_W'(DVD_W));
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    spd_nxt = spd_r;
    act_nxt = act_r;
    case (item_r.cmd)
      CMD_SET_PULSE, CMD_SET_ANGLE: begin
        cur_nxt = p_r;
        tgt_nxt = p_r;
        act_nxt = 1'b0;
      end
      CMD_SMOOTH_PULSE, CMD_SMOOTH_ANGLE: begin
        tgt_nxt = p_r;
        act_nxt = 1'b1;
        if (stat.smooth_div && (need > spd_r)) begin
          spd_nxt = need;
        end
      end
      CMD_SET_SPEED: begin
        if (item_r.speed_q8 != 24'd0) begin
          spd_nxt = item_r.speed_q8;
        end
      end
      CMD_STOP: act_nxt = 1'b0;
      CMD_TICK: begin
        if (act_r && (item_r.elapsed_ms != 16'd0)) begin
          if (tgt_r == cur_r) begin
            act_nxt = 1'b0;
          end else if (40'(dist_t) <= move) begin
            cur_nxt = tgt_r;
            act_nxt = 1'b0;
          end else if (tgt_r > cur_r) begin
            cur_nxt = cur_r + move[15:0];
          end else begin
            cur_nxt = cur_r - move[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= MIN_PULSE_RST;
      max_r       <= MAX_PULSE_RST;
      cur_r       <= PULSE_RST;
      tgt_r       <= PULSE_RST;
      spd_r       <= SPEED_RST;
      act_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_PULSE: min_r <= cfg_wdata;
          CFG_MAX_PULSE: max_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctl.apply) begin
        cur_r <= cur_nxt;
        tgt_r <= tgt_nxt;
        spd_r <= spd_nxt;
        act_r <= act_nxt;
      end
      if (ctl.div_init) begin
        cnt_r <= '0;
      end else if (ctl.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (ctl.prep) begin
      p_r    <= clamped;
      prod_r <= 40'(spd_r) * 40'(item_r.elapsed_ms);
    end
    if (ctl.div_init) begin
      dvd_r <= {dist_p, {SPEED_FRAC_BITS{1'b0}}};
      rem_r <= '0;
    end else if (ctl.div_step) begin
      // restoring step: keep the difference when the divisor fits
      if (!diff[16]) begin
        rem_r <= diff[15:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[15:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
    if (ctl.out_load) begin
      out_data_r.compare_us <= prod10[31:19];
      out_data_r.current    <= cur_r;
      out_data_r.target     <= tgt_r;
      out_data_r.moving     <= act_r;
      out_data_r.speed_now  <= spd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/servo_pulse_slew_ramp_top.sv -----
// Servo pulse ramp generator: takes one command word at a time and returns one status word
// (compare value, current and target pulse in 0.1 us, moving flag, ramp speed) per command.
// Each command passes the prep, apply and out states; smooth moves with a nonzero duration
// also pass dist and div, where the bit-serial restoring divider computes the move speed.
// A finished word waits in the output register without blocking the next accept; the block
// only holds when that register is still full at the end of the following command. Limits
// are written through cfg_* by the user only while idle; the block does not enforce it.
module servo_pulse_slew_ramp_top
  import spsr_pkg::*;
#(
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  spsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  spsr_dpath #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/spsr_check.sv -----
module spsr_check
  import spsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // a new result only shows while a command is being worked
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no command in flight");

  a_compare_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (17'(out_data.compare_us) * 17'd10 <= 17'(out_data.current)) &&
                  (17'(out_data.current) - 17'(out_data.compare_us) * 17'd10 < 17'd10))
    else $error("compare value is not current pulse divided by ten");

endmodule

bind servo_pulse_slew_ramp_top spsr_check u_check (.*);
